// ===== hdl/mqbj_pkg.sv =====
// shared types and constants of the multi-queue batch join
package mqbj_pkg;

   // fixed field widths
   localparam int ENTITY_W  = 16;
   localparam int PORT_W    = 3;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_COUNT = 1'b1;

   // register reset values
   localparam logic [CFG_W-1:0] MATCH_SIZE_RESET  = 4'd1;
   localparam logic [CFG_W-1:0] QUEUE_COUNT_RESET = 4'd2;

   // input transaction
   typedef struct packed {
      logic [PORT_W-1:0]   port;
      logic [ENTITY_W-1:0] entity_id;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [ENTITY_W-1:0] entity_out;
      logic [PORT_W-1:0]   source_queue;
      logic                dropped;
      logic                last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic clear_cnt;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad;
      logic ready;
      logic final_step;
   } status_type;

endpackage

// ===== hdl/mqbj_ram.sv =====
// generic simple dual-port ram with registered read
module mqbj_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mqbj_ctrl.sv =====
// controller state machine: accept, readiness check, batch release
module mqbj_ctrl
   import mqbj_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CHECK   = 2'd1;
   localparam logic [1:0] ST_RELEASE = 2'd2;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.clear_cnt = 1'b0;
      cmd.step      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = status.bad ? ST_IDLE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.clear_cnt = 1'b1;
            state_in      = status.ready ? ST_RELEASE : ST_IDLE;
         end
         ST_RELEASE: begin
            cmd.step = 1'b1;
            if (status.final_step) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/mqbj_dp.sv =====
// datapath: config registers, queue pointers and counts, entity store, result registers
module mqbj_dp
   import mqbj_pkg::*;
#(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_MATCH   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_item,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item
);

   localparam int QW = $clog2(NUM_QUEUES);
   localparam int NW = $clog2(NUM_QUEUES + 1);
   localparam int MW = $clog2(MAX_MATCH + 1);
   localparam int HW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

   logic [CFG_W-1:0] match_size_ff, queue_count_ff;
   logic [NW-1:0]    nq_eff;
   logic [MW-1:0]    m_eff;

   logic [HW-1:0] head_ff [NUM_QUEUES];
   logic [HW-1:0] head_in [NUM_QUEUES];
   logic [FW-1:0] fill_ff [NUM_QUEUES];
   logic [FW-1:0] fill_in [NUM_QUEUES];

   logic [QW-1:0] q_ff, q_in;
   logic [MW-1:0] i_ff, i_in;

   logic [QW-1:0] pidx;
   logic          port_in_range;
   logic          port_full;
   logic          append;
   logic [HW:0]   slot_sum;
   logic [HW-1:0] slot;
   logic          all_ready;
   logic          last_step;

   logic [AW-1:0]       wr_addr, rd_addr;
   logic [ENTITY_W-1:0] rd_data;

   logic                rd_v_ff, drop_v_ff;
   logic [QW-1:0]       rd_q_ff;
   logic                rd_last_ff;
   logic [PORT_W-1:0]   drop_port_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         match_size_ff  <= MATCH_SIZE_RESET;
         queue_count_ff <= QUEUE_COUNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MATCH_SIZE:  match_size_ff  <= csr_wdata;
            CSR_QUEUE_COUNT: queue_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // saturated match size and queue count
   assign m_eff  = (match_size_ff > CFG_W'(MAX_MATCH)) ? MW'(MAX_MATCH) : MW'(match_size_ff);
   assign nq_eff = (queue_count_ff > CFG_W'(NUM_QUEUES)) ? NW'(NUM_QUEUES)
                                                          : NW'(queue_count_ff);

   // arrival check: bad port or full queue
   assign pidx          = req_item.port[QW-1:0];
   assign port_in_range = ({1'b0, req_item.port} < 4'(nq_eff));
   assign port_full     = port_in_range ? (fill_ff[pidx] == FW'(QUEUE_DEPTH)) : 1'b0;
   assign status.bad    = !port_in_range || port_full;
   assign append        = cmd.accept && !status.bad;

   // tail slot, head plus count wrapped once
   assign slot_sum = (HW+1)'(head_ff[pidx]) + (HW+1)'(fill_ff[pidx]);
   assign slot     = (slot_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                     HW'(slot_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(slot_sum);
   assign wr_addr  = AW'(pidx) * AW'(QUEUE_DEPTH) + AW'(slot);

   // every active queue holds a full batch
   always_comb begin
      all_ready = (m_eff != '0);
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if ((q < 32'(nq_eff)) && (32'(fill_ff[q]) < 32'(m_eff))) begin
            all_ready = 1'b0;
         end
      end
   end
   assign status.ready = all_ready;

   // release position: queue and entry within the batch
   assign last_step         = (32'(i_ff) == 32'(m_eff) - 1);
   assign status.final_step = last_step && (32'(q_ff) == 32'(nq_eff) - 1);
   assign rd_addr           = AW'(q_ff) * AW'(QUEUE_DEPTH) + AW'(head_ff[q_ff]);

   always_comb begin
      q_in = q_ff;
      i_in = i_ff;
      if (cmd.clear_cnt) begin
         q_in = '0;
         i_in = '0;
      end else if (cmd.step) begin
         if (last_step) begin
            i_in = '0;
            q_in = q_ff + 1'b1;
         end else begin
            i_in = i_ff + 1'b1;
         end
      end
   end

   // head pointer and fill count updates
   always_comb begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
         head_in[q] = head_ff[q];
         fill_in[q] = fill_ff[q];
      end
      if (append) begin
         fill_in[pidx] = fill_ff[pidx] + 1'b1;
      end
      if (cmd.step) begin
         fill_in[q_ff] = fill_ff[q_ff] - 1'b1;
         head_in[q_ff] = (head_ff[q_ff] == HW'(QUEUE_DEPTH - 1)) ? '0 : head_ff[q_ff] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= '0;
            fill_ff[q] <= '0;
         end
         q_ff <= '0;
         i_ff <= '0;
      end else begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= head_in[q];
            fill_ff[q] <= fill_in[q];
         end
         q_ff <= q_in;
         i_ff <= i_in;
      end
   end

   // entity store, one region per queue
   mqbj_ram #(
      .WIDTH (ENTITY_W),
      .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (append),
      .wr_addr (wr_addr),
      .wr_data (req_item.entity_id),
      .rd_en   (cmd.step),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result control, aligned with the ram read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         drop_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.step;
         drop_v_ff <= cmd.accept && status.bad;
      end
   end

   // result payload side info
   always_ff @(posedge clock) begin
      rd_q_ff      <= q_ff;
      rd_last_ff   <= status.final_step;
      drop_port_ff <= req_item.port;
   end

   // result transaction
   assign rsp_strobe = rd_v_ff || drop_v_ff;
   always_comb begin
      if (drop_v_ff) begin
         rsp_item.entity_out   = '0;
         rsp_item.source_queue = drop_port_ff;
         rsp_item.dropped      = 1'b1;
         rsp_item.last         = 1'b1;
      end else begin
         rsp_item.entity_out   = rd_data;
         rsp_item.source_queue = PORT_W'(rd_q_ff);
         rsp_item.dropped      = 1'b0;
         rsp_item.last         = rd_last_ff;
      end
   end

endmodule

// ===== hdl/multi_queue_batch_join_top.sv =====
// top level of the multi-queue batch join
//
//   channel   ports                              handshake
//   input     start, busy, req_item              taken when start && !busy
//   result    rsp_strobe, rsp_item               one cycle per transaction, no stall
//   config    csr_write_en, csr_index, csr_wdata taken when csr_write_en
//
// a rejected arrival gives its drop result in the cycle after acceptance; busy stays low
// a stored arrival keeps busy high through the readiness check when nothing is released
// a release keeps busy high through the check and the release steps, one ram read
// per cycle on the store port; results stream one per cycle, each in the cycle after
// its read, the last one in the first cycle with busy low
// synchronous reset empties all queues; the receiver cannot stall results
module multi_queue_batch_join_top
   import mqbj_pkg::*;
#(
   parameter int NUM_QUEUES  = 8,
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_MATCH   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // control
   mqbj_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // queues and results
   mqbj_dp #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_MATCH   (MAX_MATCH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_item     (req_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_strobe   (rsp_strobe),
      .rsp_item     (rsp_item)
   );

endmodule

// ===== hdl/mqbj_chk.sv =====
// port-level checker for the multi-queue batch join, bound to the top level
module mqbj_chk
   import mqbj_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // no result in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // a drop result carries a zero entity and ends its transaction
   a_drop_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.dropped) |-> (rsp_item.entity_out == '0 && rsp_item.last))
      else $error("malformed drop result");

   // an accepted transaction either keeps the block busy or drops at once
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || (rsp_strobe && rsp_item.dropped)))
      else $error("accepted transaction produced no activity");

   // a batch streams without gaps until its last result
   a_batch_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.dropped && !rsp_item.last) |=>
      (rsp_strobe && !rsp_item.dropped))
      else $error("gap inside a released batch");

endmodule

bind multi_queue_batch_join_top mqbj_chk u_chk (.*);

// ===== sim/tb.sv =====
// self-checking testbench of the multi-queue batch join
module tb;
   import mqbj_pkg::*;

   localparam int NUM_QUEUES  = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_MATCH   = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 40;
   localparam int NUM_PHASES  = 7;

   // expected behavior of the join, fed from what the block accepts
   class batch_join_scoreboard;
      logic [ENTITY_W-1:0] queue_mem [NUM_QUEUES][QUEUE_DEPTH];
      int unsigned         head [NUM_QUEUES];
      int unsigned         fill [NUM_QUEUES];
      logic [CFG_W-1:0]    match_size;
      logic [CFG_W-1:0]    queue_count;
      rsp_type             expected_releases [$];
      int                  errors;

      function new();
         foreach (head[q]) begin
            head[q] = 0;
            fill[q] = 0;
         end
         match_size  = MATCH_SIZE_RESET;
         queue_count = QUEUE_COUNT_RESET;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         if (idx == CSR_MATCH_SIZE)
            match_size = data;
         else if (idx == CSR_QUEUE_COUNT)
            queue_count = data;
      endfunction

      function int pending();
         return expected_releases.size();
      endfunction

      // append the arrival and queue up any drop or batch it causes
      function void note_arrival(req_type r);
         int unsigned nq;
         int unsigned m;
         int unsigned p;
         bit          ready;
         rsp_type     res;
         nq = (queue_count > NUM_QUEUES) ? NUM_QUEUES : 32'(queue_count);
         m  = (match_size > MAX_MATCH) ? MAX_MATCH : 32'(match_size);
         p  = 32'(r.port);
         // bad port or full queue: a single drop result
         if (p >= nq || fill[p] >= QUEUE_DEPTH) begin
            res.entity_out   = '0;
            res.source_queue = r.port;
            res.dropped      = 1'b1;
            res.last         = 1'b1;
            expected_releases.push_back(res);
            return;
         end
         queue_mem[p][(head[p] + fill[p]) % QUEUE_DEPTH] = r.entity_id;
         fill[p]++;
         if (m == 0)
            return;
         ready = 1'b1;
         for (int q = 0; q < nq; q++)
            if (fill[q] < m)
               ready = 1'b0;
         if (!ready)
            return;
         // release m from each active queue, queue 0 first
         for (int q = 0; q < nq; q++) begin
            for (int i = 0; i < m; i++) begin
               res.entity_out   = queue_mem[q][head[q]];
               res.source_queue = q[PORT_W-1:0];
               res.dropped      = 1'b0;
               res.last         = (q == nq - 1) && (i == m - 1);
               expected_releases.push_back(res);
               head[q] = (head[q] + 1) % QUEUE_DEPTH;
               fill[q]--;
            end
         end
      endfunction

      // compare one result transaction with the oldest expectation
      function void check_output(rsp_type got);
         rsp_type want;
         if (expected_releases.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t unexpected result: expected none,", $time,
                        " actual ent=%h q=%0d drop=%b last=%b",
                        got.entity_out, got.source_queue, got.dropped, got.last);
            return;
         end
         want = expected_releases.pop_front();
         if (got.entity_out !== want.entity_out || got.source_queue !== want.source_queue ||
             got.dropped !== want.dropped || got.last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t mismatch: expected ent=%h q=%0d drop=%b last=%b,",
                        $time, want.entity_out, want.source_queue, want.dropped, want.last,
                        " actual ent=%h q=%0d drop=%b last=%b",
                        got.entity_out, got.source_queue, got.dropped, got.last);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_item;
   logic                 rsp_strobe;
   rsp_type              rsp_item;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   batch_join_scoreboard sb;
   int                   cycle_count = 0;

   // random phases: match size, queue count, transactions, sender idle percent
   int phase_match [NUM_PHASES] = '{3, 8, 0, 15, 1, 2, 4};
   int phase_nq    [NUM_PHASES] = '{8, 8, 1, 2, 1, 15, 5};
   int phase_items [NUM_PHASES] = '{30, 60, 20, 30, 20, 30, 20};
   int idle_modes  [3]          = '{0, 86, 20};

   multi_queue_batch_join_top #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_MATCH   (MAX_MATCH)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .rsp_strobe   (rsp_strobe),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // monitor of accepted transactions, config writes and results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en)
            sb.write_reg(csr_index, csr_wdata);
         if (start && !busy)
            sb.note_arrival(req_item);
         if (rsp_strobe)
            sb.check_output(rsp_item);
      end
   end

   // one arrival, with random sender gaps in front of it
   task automatic send_item(input logic [PORT_W-1:0] p, input logic [ENTITY_W-1:0] id,
                            input int idle_pct);
      req_type r;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      r.port      = p;
      r.entity_id = id;
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // stop sending and let every expected result come out
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // write both registers while the block is idle
   task automatic set_config(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] nq);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MATCH_SIZE;
      csr_wdata    <= m;
      @(posedge clock);
      csr_index    <= CSR_QUEUE_COUNT;
      csr_wdata    <= nq;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      int                  idle_pct;
      int                  nq_eff;
      logic [PORT_W-1:0]   p;
      logic [ENTITY_W-1:0] id;
      sb = new();
      reset        <= 1'b1;
      start        <= 1'b0;
      req_item     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_MATCH_SIZE;
      csr_wdata    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: pairs release, bad ports drop
      send_item(3'd0, 16'h0000, 0);
      send_item(3'd1, 16'hffff, 0);
      send_item(3'd2, 16'h1234, 0);
      send_item(3'd7, 16'hffff, 0);
      send_item(3'd1, 16'h0001, 0);
      send_item(3'd1, 16'h8000, 0);
      send_item(3'd0, 16'h7fff, 0);

      // match size above the maximum saturates, one queue
      set_config(4'd15, 4'd1);
      for (int i = 0; i < MAX_MATCH; i++)
         send_item(3'd0, (i[0] ? 16'hffff : 16'h0000) ^ i[15:0], 0);

      // queue count zero drops everything
      set_config(4'd1, 4'd0);
      send_item(3'd0, 16'h5555, 0);
      send_item(3'd3, 16'haaaa, 0);

      // match size zero stores without release
      set_config(4'd0, 4'd8);
      send_item(3'd5, 16'h1111, 0);
      send_item(3'd1, 16'h2222, 0);

      // stale entries of queue 1 join a later batch
      set_config(4'd2, 4'd2);
      send_item(3'd0, 16'h3333, 0);
      send_item(3'd0, 16'h4444, 0);

      // random phases, mostly arrivals on active ports
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_config(phase_match[ph][CFG_W-1:0], phase_nq[ph][CFG_W-1:0]);
         idle_pct = idle_modes[ph % 3];
         nq_eff   = (phase_nq[ph] > NUM_QUEUES) ? NUM_QUEUES : phase_nq[ph];
         for (int i = 0; i < phase_items[ph]; i++) begin
            if ($urandom_range(99) < 85 && nq_eff > 0)
               p = PORT_W'($urandom_range(nq_eff - 1));
            else
               p = PORT_W'($urandom_range(NUM_QUEUES - 1));
            case ($urandom_range(9))
               0: id = 16'h0000;
               1: id = 16'hffff;
               default: id = ENTITY_W'($urandom_range(65535));
            endcase
            send_item(p, id, idle_pct);
         end
      end

      // drain and report
      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
